>>> hw/rtl/stp_pkg.sv
// ----------------------------------------------------------------------------
// stp_pkg
// shared widths, codes and the result record of the stepper axis block
// ----------------------------------------------------------------------------
package stp_pkg;

  localparam int POSITION_WIDTH = 24;
  localparam int DELAY_WIDTH    = 16;
  localparam int MAX_W          = 23;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 23;

  // request kinds carried in the action field
  localparam logic [1:0] ACT_TICK    = 2'd0;
  localparam logic [1:0] ACT_STEP    = 2'd1;
  localparam logic [1:0] ACT_HOME    = 2'd2;
  localparam logic [1:0] ACT_SET_POS = 2'd3;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_REV_END  = 3'd1;
  localparam logic [2:0] ST_FWD_END  = 3'd2;
  localparam logic [2:0] ST_POS_OVER = 3'd3;
  localparam logic [2:0] ST_BUSY     = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEPS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_LOW_TICKS = 2'd1;

  localparam logic [MAX_W-1:0]       MAX_STEPS_RST      = 23'd8388607;
  localparam logic [DELAY_WIDTH-1:0] STEP_LOW_TICKS_RST = 16'd1000;

  typedef struct packed {
    logic                             step_out;
    logic                             dir_out;
    logic [2:0]                       status;
    logic signed [POSITION_WIDTH-1:0] position;
    logic                             busy_res;
    logic                             home_done;
  } stp_result_t;

endpackage

>>> hw/rtl/stp_axis_core.sv
// ----------------------------------------------------------------------------
// stp_axis_core
// axis state, configuration registers and the per-request update logic
// ----------------------------------------------------------------------------
module stp_axis_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         req_fire,
  input  logic [1:0]                   action,
  input  logic                         direction,
  input  logic                         endstop_hit,
  input  logic [stp_pkg::MAX_W-1:0]    new_position,
  input  logic                         cfg_fire,
  input  logic [stp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [stp_pkg::CFG_DATA_W-1:0] cfg_data,
  output stp_pkg::stp_result_t         result
);
  import stp_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE, PH_STEP_LOW, PH_HOME_SEEK, PH_HOME_REV_LOW, PH_HOME_RELEASE, PH_HOME_FWD_LOW
  } phase_t;

  phase_t                    phase_r, phase_nxt;
  logic [POSITION_WIDTH-1:0] pos_r, pos_nxt;
  logic [DELAY_WIDTH-1:0]    cnt_r, cnt_nxt;
  logic                      dir_r, dir_nxt;
  logic                      lvl_r, lvl_nxt;
  logic [MAX_W-1:0]          max_steps_r;
  logic [DELAY_WIDTH-1:0]    low_ticks_r;
  logic [2:0]                status;
  logic                      done;
  logic                      fwd_limit;
  logic                      in_pulse;
  logic                      do_release;
  phase_t                    pulse_next;

  // forward limit: signed position at or beyond the limit
  assign fwd_limit = $signed(pos_r) >=
                     $signed({{(POSITION_WIDTH-MAX_W){1'b0}}, max_steps_r});

  assign in_pulse = (phase_r == PH_STEP_LOW) || (phase_r == PH_HOME_REV_LOW) ||
                    (phase_r == PH_HOME_FWD_LOW);

  // seek with the end-stop hit goes on to the release decision at once
  assign do_release = (phase_r == PH_HOME_RELEASE) ||
                      ((phase_r == PH_HOME_SEEK) && endstop_hit);

  // phase entered after the step edge of a pulse
  always_comb begin
    case (phase_r)
      PH_HOME_REV_LOW: pulse_next = PH_HOME_SEEK;
      PH_HOME_FWD_LOW: pulse_next = PH_HOME_RELEASE;
      default:         pulse_next = PH_IDLE;
    endcase
  end

  // next state and status for one request
  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    cnt_nxt   = cnt_r;
    dir_nxt   = dir_r;
    lvl_nxt   = lvl_r;
    status    = ST_OK;
    done      = 1'b0;
    if (action == ACT_TICK) begin
      if (in_pulse) begin
        if (cnt_r != '0) begin
          cnt_nxt = cnt_r - 1'b1;
        end else begin
          lvl_nxt   = 1'b1;
          pos_nxt   = dir_r ? pos_r + 1'b1 : pos_r - 1'b1;
          phase_nxt = pulse_next;
        end
      end else if (do_release) begin
        if (!endstop_hit) begin
          pos_nxt   = '0;
          done      = 1'b1;
          phase_nxt = PH_IDLE;
        end else if (fwd_limit) begin
          status    = ST_FWD_END;
          phase_nxt = PH_IDLE;
        end else begin
          dir_nxt   = 1'b1;
          lvl_nxt   = 1'b0;
          cnt_nxt   = low_ticks_r;
          phase_nxt = PH_HOME_FWD_LOW;
        end
      end else if (phase_r == PH_HOME_SEEK) begin
        dir_nxt   = 1'b0;
        lvl_nxt   = 1'b0;
        cnt_nxt   = low_ticks_r;
        phase_nxt = PH_HOME_REV_LOW;
      end else begin
        phase_nxt = PH_IDLE;
      end
    end else if (phase_r != PH_IDLE) begin
      status = ST_BUSY;
    end else begin
      case (action)
        ACT_STEP: begin
          if (!direction && endstop_hit) begin
            status = ST_REV_END;
          end else if (direction && fwd_limit) begin
            status = ST_FWD_END;
          end else begin
            dir_nxt   = direction;
            lvl_nxt   = 1'b0;
            cnt_nxt   = low_ticks_r;
            phase_nxt = PH_STEP_LOW;
          end
        end
        ACT_HOME: phase_nxt = PH_HOME_SEEK;
        default: begin
          if (new_position > max_steps_r) begin
            status = ST_POS_OVER;
          end else begin
            pos_nxt = {{(POSITION_WIDTH-MAX_W){1'b0}}, new_position};
          end
        end
      endcase
    end
  end

  // result of the request, taken by the output buffer on the same edge
  always_comb begin
    result.step_out  = lvl_nxt;
    result.dir_out   = dir_nxt;
    result.status    = status;
    result.position  = $signed(pos_nxt);
    result.busy_res  = (phase_nxt != PH_IDLE);
    result.home_done = done;
  end

  // state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      pos_r       <= '0;
      cnt_r       <= '0;
      dir_r       <= 1'b0;
      lvl_r       <= 1'b1;
      max_steps_r <= MAX_STEPS_RST;
      low_ticks_r <= STEP_LOW_TICKS_RST;
    end else begin
      if (req_fire) begin
        phase_r <= phase_nxt;
        pos_r   <= pos_nxt;
        cnt_r   <= cnt_nxt;
        dir_r   <= dir_nxt;
        lvl_r   <= lvl_nxt;
      end
      if (cfg_fire) begin
        case (cfg_index)
          CFG_MAX_STEPS:      max_steps_r <= cfg_data[MAX_W-1:0];
          CFG_STEP_LOW_TICKS: low_ticks_r <= cfg_data[DELAY_WIDTH-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

>>> hw/rtl/stp_out_buf.sv
// ----------------------------------------------------------------------------
// stp_out_buf
// output register with a skid stage so a new request is taken while a
// result still waits
// ----------------------------------------------------------------------------
module stp_out_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  stp_pkg::stp_result_t push_data,
  output logic                 can_push,
  output logic                 out_valid,
  input  logic                 out_ready,
  output stp_pkg::stp_result_t out_data
);
  import stp_pkg::*;

  logic        out_valid_r;
  logic        skid_valid_r;
  stp_result_t out_data_r;
  stp_result_t skid_data_r;
  logic        pop;

  assign can_push  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pop       = out_valid_r && out_ready;

  // control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || pop) begin
      out_valid_r  <= skid_valid_r || push;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      out_data_r <= skid_valid_r ? skid_data_r : push_data;
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

endmodule

>>> hw/rtl/stepper_axis_step_limit_homing.sv
// ----------------------------------------------------------------------------
// stepper_axis_step_limit_homing
// one stepper axis: step/dir drive, position count, limits and homing
// ----------------------------------------------------------------------------
//  channel  dir  handshake               payload
//  in_      in   in_valid / in_ready     action, direction, endstop_hit,
//                                        new_position
//  out_     out  out_valid / out_ready   step_out, dir_out, status, position,
//                                        busy_res, home_done
//  cfg_     in   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// one request per clock while in_ready is high; its result is registered
// the rate is set by the state update in the axis core
// reset (synchronous, rst_n low) sets idle, position zero, step pin high
// a stalled result is held and one more request lands in the skid stage;
// in_ready drops only while both are full
// cfg_ready is always high
// ----------------------------------------------------------------------------
module stepper_axis_step_limit_homing (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_action,
  input  logic                                in_direction,
  input  logic                                in_endstop_hit,
  input  logic [stp_pkg::MAX_W-1:0]           in_new_position,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_step_out,
  output logic                                out_dir_out,
  output logic [2:0]                          out_status,
  output logic signed [stp_pkg::POSITION_WIDTH-1:0] out_position,
  output logic                                out_busy_res,
  output logic                                out_home_done,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [stp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [stp_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import stp_pkg::*;

  stp_result_t core_res;
  stp_result_t buf_res;
  logic        req_fire;

  assign cfg_ready = 1'b1;
  assign req_fire  = in_valid && in_ready;

  // axis state and update
  stp_axis_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_fire     (req_fire),
    .action       (in_action),
    .direction    (in_direction),
    .endstop_hit  (in_endstop_hit),
    .new_position (in_new_position),
    .cfg_fire     (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result       (core_res)
  );

  // result register and skid
  stp_out_buf u_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (req_fire),
    .push_data (core_res),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (buf_res)
  );

  assign out_step_out  = buf_res.step_out;
  assign out_dir_out   = buf_res.dir_out;
  assign out_status    = buf_res.status;
  assign out_position  = buf_res.position;
  assign out_busy_res  = buf_res.busy_res;
  assign out_home_done = buf_res.home_done;

  // checks
  a_ready_implies_slot: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("request blocked with no result pending");

  a_home_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_home_done) |-> (out_position == '0 && !out_busy_res))
    else $error("homing finished without zero position or still busy");

  a_busy_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_BUSY) |-> out_busy_res)
    else $error("busy status while idle");

  a_low_pin_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_step_out) |-> out_busy_res)
    else $error("step pin low outside a pulse");

  a_accept_shows: assert property (@(posedge clk) disable iff (!rst_n)
    req_fire |=> out_valid)
    else $error("accepted request left no result");

endmodule
